// ===== hw/rtl/lphm_pkg.sv =====
// Shared constants, types and hash step for the linear-probe hash map.
package lphm_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int CNT_W       = 10;
    localparam int PADDR_W     = 1;

    localparam logic [63:0] HASH_BASIS = 64'hCBF29CE484222325;
    // FNV prime is 2^40 + 0x1B3
    localparam logic [8:0]  HASH_LOW   = 9'h1B3;

    localparam logic [CNT_W-1:0] MAX_RESET = CNT_W'(512);
    localparam logic [CNT_W-1:0] DEPTH_M1  = CNT_W'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        ACT_GET    = 2'd0,
        ACT_SET    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_KEY = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [ADDR_W-1:0] home;
    } item_t;

    function automatic logic [63:0] hash_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        logic [63:0] lo;
        begin
            x  = h ^ {56'd0, b};
            lo = x * {55'd0, HASH_LOW};
            hash_step = (x << 40) + lo;
        end
    endfunction

endpackage

// ===== hw/rtl/linear_probe_hash_map.sv =====
// Top level of the linear-probe hash map: APB register, front end and back end.
// Each item gives exactly one result, shown for one cycle with done high; the receiver
// cannot stall it. The front end hashes the key one FNV-1a byte per cycle and queues
// up to two hashed items; the back end reads and checks each probed slot of the key RAM
// read port (B_RD, B_CHK), and on a remove hit each following cluster slot as well. Clear
// sweeps the 1024 slots one per cycle. After reset the same sweep runs with busy high.
module linear_probe_hash_map (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lphm_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      action,
    input  logic [lphm_pkg::KEY_W-1:0]      key,
    input  logic [lphm_pkg::VAL_W-1:0]      value,
    output logic                            done,
    output logic                            found,
    output logic [lphm_pkg::VAL_W-1:0]      read_value,
    output logic [1:0]                      status,
    output logic [lphm_pkg::CNT_W-1:0]      entry_count
);

    logic [lphm_pkg::CNT_W-1:0] max_entries_reg;
    logic                       q_valid, q_pop, init_busy;
    lphm_pkg::item_t            q_item;

    assign pready = 1'b1;
    assign prdata = (paddr == '0) ? {22'd0, max_entries_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= lphm_pkg::MAX_RESET;
        end
        else if (psel && penable && pwrite && (paddr == '0))
        begin
            max_entries_reg <= pwdata[lphm_pkg::CNT_W-1:0];
        end
    end

    lphm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .hold    (init_busy),
        .busy    (busy),
        .action  (action),
        .key     (key),
        .value   (value),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    lphm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_entries (max_entries_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .init_busy   (init_busy),
        .done        (done),
        .found       (found),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count)
    );

endmodule

// ===== hw/rtl/lphm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lphm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/lphm_front.sv =====
// Front end: takes items, hashes the key to a home slot, queues for the back end.
module lphm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  hold,
    output logic                  busy,
    input  logic [1:0]            action,
    input  logic [lphm_pkg::KEY_W-1:0] key,
    input  logic [lphm_pkg::VAL_W-1:0] value,
    output logic                  q_valid,
    output lphm_pkg::item_t       q_item,
    input  logic                  q_pop
);

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

    fstate_t                      state_reg, state_next;
    logic [2:0]                   idx_reg, idx_next;
    logic [63:0]                  h_reg, h_next;
    logic [1:0]                   act_reg;
    logic [lphm_pkg::KEY_W-1:0]   key_reg;
    logic [lphm_pkg::VAL_W-1:0]   val_reg;

    lphm_pkg::item_t              fifo_reg [2];
    logic                         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                   fill_reg;
    logic                         push, accept;

    assign accept  = start && !busy;
    assign busy    = (state_reg != F_IDLE) || hold;
    assign push    = (state_reg == F_PUSH) && (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        h_next     = h_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_HASH;
                    idx_next   = 3'd0;
                    h_next     = lphm_pkg::HASH_BASIS;
                end
            end
            F_HASH:
            begin
                h_next   = lphm_pkg::hash_step(h_reg, key_reg[idx_reg*8 +: 8]);
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        h_reg   <= h_next;
        if (accept)
        begin
            act_reg <= action;
            key_reg <= key;
            val_reg <= value;
        end
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{action: act_reg, key: key_reg, value: val_reg,
                                      home: h_reg[lphm_pkg::ADDR_W-1:0]};
        end
    end

endmodule

// ===== hw/rtl/lphm_back.sv =====
// Back end: probe walk, insert, remove with cluster repair, table clearing.
module lphm_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lphm_pkg::CNT_W-1:0]   max_entries,
    input  logic                         q_valid,
    input  lphm_pkg::item_t              q_item,
    output logic                         q_pop,
    output logic                         init_busy,
    output logic                         done,
    output logic                         found,
    output logic [lphm_pkg::VAL_W-1:0]   read_value,
    output logic [1:0]                   status,
    output logic [lphm_pkg::CNT_W-1:0]   entry_count
);

    localparam int AW = lphm_pkg::ADDR_W;
    localparam int KW = lphm_pkg::KEY_W + lphm_pkg::ADDR_W;

    typedef enum logic [2:0] {B_IDLE, B_RD, B_CHK, B_SCAN_RD, B_SCAN_CHK, B_CLR} bstate_t;

    bstate_t                    state_reg, state_next;
    logic                       init_reg, init_next;
    logic [1:0]                 act_reg, act_next;
    logic [lphm_pkg::KEY_W-1:0] key_reg, key_next;
    logic [lphm_pkg::VAL_W-1:0] val_reg, val_next;
    logic [AW-1:0]              home_reg, home_next;
    logic [AW-1:0]              slot_reg, slot_next;
    logic [AW-1:0]              hole_reg, hole_next;
    logic [lphm_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic                       done_reg, done_next;
    logic                       found_reg, found_next;
    logic [lphm_pkg::VAL_W-1:0] rd_reg, rd_next;
    logic [1:0]                 status_reg, status_next;

    logic                       k_we, v_we;
    logic [AW-1:0]              k_waddr, v_waddr;
    logic [KW-1:0]              k_wdata, k_rdata;
    logic [lphm_pkg::VAL_W-1:0] v_wdata, v_rdata;

    logic [lphm_pkg::KEY_W-1:0] rd_key;
    logic [AW-1:0]              rd_home;
    logic [lphm_pkg::CNT_W-1:0] limit;
    logic                       move;

    assign rd_key  = k_rdata[lphm_pkg::KEY_W-1:0];
    assign rd_home = k_rdata[KW-1:lphm_pkg::KEY_W];
    assign limit   = (max_entries > lphm_pkg::DEPTH_M1) ? lphm_pkg::DEPTH_M1 : max_entries;
    // entry moves into the hole when the hole lies between its home and its slot
    assign move    = ((hole_reg - rd_home) < (slot_reg - rd_home));

    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign init_busy = init_reg;

    lphm_ram #(.WIDTH(KW), .DEPTH(lphm_pkg::TABLE_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (slot_reg),
        .rdata (k_rdata)
    );

    lphm_ram #(.WIDTH(lphm_pkg::VAL_W), .DEPTH(lphm_pkg::TABLE_DEPTH)) u_val_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (slot_reg),
        .rdata (v_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        init_next   = init_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        home_next   = home_reg;
        slot_next   = slot_reg;
        hole_next   = hole_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        found_next  = 1'b0;
        rd_next     = '0;
        status_next = lphm_pkg::ST_OK;
        k_we        = 1'b0;
        v_we        = 1'b0;
        k_waddr     = slot_reg;
        v_waddr     = slot_reg;
        k_wdata     = {home_reg, key_reg};
        v_wdata     = val_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    act_next  = q_item.action;
                    key_next  = q_item.key;
                    val_next  = q_item.value;
                    home_next = q_item.home;
                    slot_next = q_item.home;
                    if (q_item.action == lphm_pkg::ACT_CLEAR)
                    begin
                        slot_next  = '0;
                        state_next = B_CLR;
                    end
                    else if (q_item.key == '0)
                    begin
                        done_next = 1'b1;
                        if (q_item.action == lphm_pkg::ACT_SET)
                        begin
                            status_next = lphm_pkg::ST_ZERO_KEY;
                        end
                    end
                    else
                    begin
                        state_next = B_RD;
                    end
                end
            end
            B_RD:
            begin
                state_next = B_CHK;
            end
            B_CHK:
            begin
                if (rd_key == '0)
                begin
                    state_next = B_IDLE;
                    done_next  = 1'b1;
                    if (act_reg == lphm_pkg::ACT_SET)
                    begin
                        if (cnt_reg >= limit)
                        begin
                            status_next = lphm_pkg::ST_FULL;
                        end
                        else
                        begin
                            k_we     = 1'b1;
                            v_we     = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
                else if (rd_key == key_reg)
                begin
                    found_next = 1'b1;
                    unique case (act_reg)
                        lphm_pkg::ACT_GET:
                        begin
                            done_next  = 1'b1;
                            rd_next    = v_rdata;
                            state_next = B_IDLE;
                        end
                        lphm_pkg::ACT_SET:
                        begin
                            done_next  = 1'b1;
                            v_we       = 1'b1;
                            state_next = B_IDLE;
                        end
                        default:
                        begin
                            found_next = 1'b0;
                            if (cnt_reg != '0)
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                            hole_next  = slot_reg;
                            slot_next  = slot_reg + 1'b1;
                            state_next = B_SCAN_RD;
                        end
                    endcase
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = B_RD;
                end
            end
            B_SCAN_RD:
            begin
                state_next = B_SCAN_CHK;
            end
            B_SCAN_CHK:
            begin
                if (rd_key == '0)
                begin
                    k_we       = 1'b1;
                    k_waddr    = hole_reg;
                    k_wdata    = '0;
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    if (move)
                    begin
                        k_we      = 1'b1;
                        v_we      = 1'b1;
                        k_waddr   = hole_reg;
                        v_waddr   = hole_reg;
                        k_wdata   = k_rdata;
                        v_wdata   = v_rdata;
                        hole_next = slot_reg;
                    end
                    slot_next  = slot_reg + 1'b1;
                    state_next = B_SCAN_RD;
                end
            end
            B_CLR:
            begin
                k_we      = 1'b1;
                k_wdata   = '0;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == AW'(lphm_pkg::TABLE_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                    cnt_next   = '0;
                    init_next  = 1'b0;
                    done_next  = !init_reg;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLR;
            init_reg   <= 1'b1;
            slot_reg   <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            rd_reg     <= '0;
            status_reg <= lphm_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            init_reg   <= init_next;
            slot_reg   <= slot_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            rd_reg     <= rd_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        home_reg <= home_next;
        hole_reg <= hole_next;
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign read_value  = rd_reg;
    assign status      = status_reg;
    assign entry_count = cnt_reg;

endmodule

// ===== hw/rtl/lphm_checker.sv =====
// Port-level checks for the linear-probe hash map, bound to the top level.
module lphm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       done,
    input logic                       found,
    input logic [lphm_pkg::VAL_W-1:0] read_value,
    input logic [1:0]                 status
);

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == lphm_pkg::ST_OK || status == lphm_pkg::ST_ZERO_KEY ||
                  status == lphm_pkg::ST_FULL))
        else $error("undefined status code");

    a_refused_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != lphm_pkg::ST_OK) |-> !found)
        else $error("refused item reports a hit");

    a_miss_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (read_value == '0))
        else $error("miss returns nonzero value");

    a_value_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (read_value == '0 && !found))
        else $error("result ports active without done");

endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .done       (done),
    .found      (found),
    .read_value (read_value),
    .status     (status)
);

// ===== dv/tb.sv =====
// Testbench for linear_probe_hash_map: random and directed actions checked against a table model.
`timescale 1ns / 1ps

module tb;

    localparam logic [lphm_pkg::PADDR_W-1:0] REG_MAX_ENTRIES = lphm_pkg::PADDR_W'(0);
    localparam int DEPTH = 1024;
    localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
    localparam logic [63:0] HASH_MUL = 64'd1099511628211;

    typedef struct {
        lphm_pkg::action_t act;
        logic [63:0]       k;
        logic [63:0]       v;
    } op_t;

    typedef struct {
        logic              hit;
        logic [63:0]       rd;
        lphm_pkg::status_t st;
        logic [9:0]        cnt;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [lphm_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic [1:0] action = 2'd0;
    logic [63:0] key = '0;
    logic [63:0] value = '0;
    logic done;
    logic found;
    logic [63:0] read_value;
    logic [1:0] status;
    logic [9:0] entry_count;

    linear_probe_hash_map dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // table model
    logic [63:0] key_tab [DEPTH];
    logic [63:0] val_tab [DEPTH];
    logic [9:0]  n_keys = '0;
    logic [9:0]  limit_cfg = 10'd512;

    op_t     pending_ops [$];
    answer_t answers_due [$];
    logic [63:0] key_pool [$];
    int  errors = 0;
    int  gap = 0;
    bit  idle_on = 1'b1;

    function automatic int slot_of(input logic [63:0] k);
        logic [63:0] h;
        h = FNV_BASIS;
        for (int b = 0; b < 8; b++)
        begin
            h = h ^ {56'd0, k[8*b +: 8]};
            h = h * HASH_MUL;
        end
        return int'(h[9:0]);
    endfunction

    // 1 hit, 0 empty slot met, 2 table has no empty slot
    function automatic int lookup(input logic [63:0] k, output int at);
        int s;
        s = slot_of(k);
        for (int n = 0; n < DEPTH; n++)
        begin
            if (key_tab[s] == 64'd0)
            begin
                at = s;
                return 0;
            end
            if (key_tab[s] == k)
            begin
                at = s;
                return 1;
            end
            s = (s + 1) % DEPTH;
        end
        at = 0;
        return 2;
    endfunction

    function automatic void wipe_table();
        for (int i = 0; i < DEPTH; i++)
        begin
            key_tab[i] = '0;
            val_tab[i] = '0;
        end
        n_keys = '0;
    endfunction

    function automatic answer_t apply_op(input op_t op);
        answer_t a;
        int at;
        int r;
        int s;
        int a2;
        logic [9:0] lim;
        logic [63:0] mk;
        logic [63:0] mv;
        a.hit = 1'b0;
        a.rd = '0;
        a.st = lphm_pkg::ST_OK;
        lim = (limit_cfg > 10'd1023) ? 10'd1023 : limit_cfg;
        case (op.act)
            lphm_pkg::ACT_GET:
            begin
                if (op.k != 0 && lookup(op.k, at) == 1)
                begin
                    a.hit = 1'b1;
                    a.rd = val_tab[at];
                end
            end
            lphm_pkg::ACT_SET:
            begin
                if (op.k == 0)
                    a.st = lphm_pkg::ST_ZERO_KEY;
                else
                begin
                    r = lookup(op.k, at);
                    if (r == 1)
                    begin
                        a.hit = 1'b1;
                        val_tab[at] = op.v;
                    end
                    else if (r == 2 || n_keys >= lim)
                        a.st = lphm_pkg::ST_FULL;
                    else
                    begin
                        key_tab[at] = op.k;
                        val_tab[at] = op.v;
                        n_keys++;
                    end
                end
            end
            lphm_pkg::ACT_REMOVE:
            begin
                if (op.k != 0 && lookup(op.k, at) == 1)
                begin
                    a.hit = 1'b1;
                    key_tab[at] = '0;
                    val_tab[at] = '0;
                    if (n_keys > 0)
                        n_keys--;
                    // pull the rest of the cluster back toward home
                    s = (at + 1) % DEPTH;
                    for (int n = 0; n < DEPTH && key_tab[s] != 0; n++)
                    begin
                        mk = key_tab[s];
                        mv = val_tab[s];
                        key_tab[s] = '0;
                        val_tab[s] = '0;
                        if (lookup(mk, a2) != 2)
                        begin
                            key_tab[a2] = mk;
                            val_tab[a2] = mv;
                        end
                        s = (s + 1) % DEPTH;
                    end
                end
            end
            default:
                wipe_table();
        endcase
        a.cnt = n_keys;
        return a;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        op_t cur;
        op_t nxt;
        bit took;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap = 0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                cur.act = lphm_pkg::action_t'(action);
                cur.k = key;
                cur.v = value;
                answers_due.push_back(apply_op(cur));
                if (idle_on && $urandom_range(0, 5) == 0)
                    gap = $urandom_range(1, 17);
            end
            if (start && !took)
                start <= 1'b1;
            else if (gap > 0)
            begin
                gap--;
                start <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                nxt = pending_ops.pop_front();
                action <= nxt.act;
                key <= nxt.k;
                value <= nxt.v;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected result found=%0b value=%h status=%0d count=%0d",
                         $realtime, found, read_value, status, entry_count);
                errors++;
            end
            else
            begin
                e = answers_due.pop_front();
                if (found !== e.hit)
                begin
                    $display("%0t: found exp %0b got %0b", $realtime, e.hit, found);
                    errors++;
                end
                if (read_value !== e.rd)
                begin
                    $display("%0t: read_value exp %h got %h", $realtime, e.rd, read_value);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status exp %0d got %0d", $realtime, e.st, status);
                    errors++;
                end
                if (entry_count !== e.cnt)
                begin
                    $display("%0t: entry_count exp %0d got %0d", $realtime, e.cnt, entry_count);
                    errors++;
                end
            end
        end
    end

    task automatic push_op(input lphm_pkg::action_t act, input logic [63:0] k,
                           input logic [63:0] v);
        op_t op;
        op.act = act;
        op.k = k;
        op.v = v;
        pending_ops.push_back(op);
    endtask

    // wait until the block has answered everything and gone quiet
    task automatic drain();
        while (pending_ops.size() > 0 || start || answers_due.size() > 0 || gap > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [9:0] lim);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_MAX_ENTRIES;
        pwdata <= {22'd0, lim};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_cfg = lim;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic fill_pool(input int n);
        logic [63:0] k;
        key_pool.delete();
        for (int i = 0; i < n; i++)
        begin
            k = rand64();
            key_pool.push_back((k == 0) ? 64'd1 : k);
        end
    endtask

    task automatic random_ops(input int n);
        int pick;
        int act_pick;
        logic [63:0] k;
        lphm_pkg::action_t act;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                k = '0;
            else if (pick < 88)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                k = rand64();
            act_pick = $urandom_range(0, 99);
            if (act_pick < 42)
                act = lphm_pkg::ACT_SET;
            else if (act_pick < 72)
                act = lphm_pkg::ACT_GET;
            else if (act_pick < 98)
                act = lphm_pkg::ACT_REMOVE;
            else
                act = lphm_pkg::ACT_CLEAR;
            push_op(act, k, rand64());
        end
    endtask

    initial
    begin
        wipe_table();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // directed: zero key, extremes, hits, misses, clear, limits
        push_op(lphm_pkg::ACT_GET, 64'd5, 64'd0);
        push_op(lphm_pkg::ACT_SET, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_op(lphm_pkg::ACT_GET, 64'd0, 64'd0);
        push_op(lphm_pkg::ACT_REMOVE, 64'd0, 64'd0);
        push_op(lphm_pkg::ACT_SET, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_op(lphm_pkg::ACT_SET, 64'd1, 64'h0123_4567_89AB_CDEF);
        push_op(lphm_pkg::ACT_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        push_op(lphm_pkg::ACT_SET, 64'd1, 64'd0);
        push_op(lphm_pkg::ACT_GET, 64'd1, 64'd0);
        push_op(lphm_pkg::ACT_REMOVE, 64'd2, 64'd0);
        push_op(lphm_pkg::ACT_REMOVE, 64'd1, 64'd0);
        push_op(lphm_pkg::ACT_GET, 64'd1, 64'd0);
        push_op(lphm_pkg::ACT_CLEAR, 64'd7, 64'd7);
        push_op(lphm_pkg::ACT_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        set_limit(10'd2);
        push_op(lphm_pkg::ACT_SET, 64'd10, 64'd1);
        push_op(lphm_pkg::ACT_SET, 64'd11, 64'd2);
        push_op(lphm_pkg::ACT_SET, 64'd12, 64'd3);
        push_op(lphm_pkg::ACT_SET, 64'd10, 64'd4);
        push_op(lphm_pkg::ACT_REMOVE, 64'd10, 64'd0);
        push_op(lphm_pkg::ACT_SET, 64'd12, 64'd5);
        set_limit(10'd0);
        push_op(lphm_pkg::ACT_SET, 64'd13, 64'd6);
        push_op(lphm_pkg::ACT_GET, 64'd12, 64'd0);
        push_op(lphm_pkg::ACT_CLEAR, 64'd0, 64'd0);
        push_op(lphm_pkg::ACT_SET, 64'd14, 64'd7);
        set_limit(10'd512);

        fill_pool(120);
        random_ops(200);
        set_limit(10'd1023);
        fill_pool(250);
        random_ops(300);
        set_limit(10'd7);
        fill_pool(20);
        random_ops(200);
        set_limit(10'd1);
        fill_pool(6);
        random_ops(100);
        set_limit(10'd0);
        random_ops(60);
        set_limit(10'($urandom_range(1, 1023)));
        fill_pool(300);
        random_ops(250);
        drain();
        idle_on = 1'b0;
        random_ops(200);

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== linear_probe_hash_map.f =====
hw/rtl/lphm_pkg.sv
hw/rtl/lphm_ram.sv
hw/rtl/lphm_front.sv
hw/rtl/lphm_back.sv
hw/rtl/linear_probe_hash_map.sv
hw/rtl/lphm_checker.sv
dv/tb.sv
